/* hw/rtl/clhc_pkg.sv */
// Shared constants for the capture link-header classifier.
`default_nettype none

package clhc_pkg;

  // Record length limit; bytes past it are dropped but their last mark counts.
  localparam int unsigned MaxRecordBytes = 65536;
  localparam int unsigned CntW = $clog2(MaxRecordBytes + 1);
  localparam int unsigned IdxW = $clog2(MaxRecordBytes);
  // Width for position arithmetic (positions + rounding never exceed this).
  localparam int unsigned PosW = 18;

  // Radiotap present-chain walk.
  localparam logic [1:0] ChainWalk      = 2'd0;
  localparam logic [1:0] ChainFlagsWait = 2'd1;
  localparam logic [1:0] ChainFlagsSeen = 2'd2;
  localparam logic [1:0] ChainNoFcs     = 2'd3;

  // Protocol codes.
  typedef enum logic [2:0] {
    ProtoNone   = 3'd0,
    ProtoIpv4   = 3'd1,
    ProtoIpv6   = 3'd2,
    ProtoEth    = 3'd3,
    ProtoWlan   = 3'd4,
    ProtoLrWpan = 3'd5,
    ProtoPpp    = 3'd6
  } proto_e;

  // Link type numbers.
  localparam logic [15:0] LinkNull       = 16'd0;
  localparam logic [15:0] LinkEthernet   = 16'd1;
  localparam logic [15:0] LinkRaw        = 16'd101;
  localparam logic [15:0] LinkWlan       = 16'd105;
  localparam logic [15:0] LinkRadiotap   = 16'd127;
  localparam logic [15:0] LinkLrWpan     = 16'd195;
  localparam logic [15:0] LinkLrWpanNoFcs = 16'd230;
  localparam logic [15:0] LinkPpp        = 16'd204;
  localparam logic [15:0] LinkIpv4       = 16'd228;
  localparam logic [15:0] LinkIpv6       = 16'd229;

  // Null-link address family values.
  localparam logic [31:0] FamInet   = 32'd2;
  localparam logic [31:0] FamInet6A = 32'd24;
  localparam logic [31:0] FamInet6B = 32'd28;
  localparam logic [31:0] FamInet6C = 32'd30;

  localparam logic [15:0] NullHdrLen = 16'd4;
  localparam logic [3:0]  IpVersion6 = 4'd6;

endpackage

`default_nettype wire

/* hw/rtl/capture_link_header_classifier.sv */
// Top level of the capture link-header classifier.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one captured byte per
//   request, data_byte_i, with last_byte_i marking the final byte of a record.
//   Output channel (out_valid_o / out_stall_i) carries one result request per
//   record: protocol_code_o, payload_offset_o, fcs_known_o, fcs_present_o.
//   cfg_we_i / cfg_wdata_i write the link type register (reset value 1); the
//   value in the register when the last byte is processed decides.
// Timing:
//   One byte per cycle while no last byte waits on a stalled output. A byte
//   passes an input register; header/chain logic then updates the running
//   state and, on a last byte, loads the result register. Non-last bytes
//   never wait on the output side.
// Reset:
//   Asynchronous, active low; clears the record state, empties both
//   registers and sets the link type to 1.
// Stall:
//   While out_stall_i holds a result, a following last byte waits in the input
//   register and in_stall_o rises; the result register holds its value.

`default_nettype none

module capture_link_header_classifier (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // config
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  // byte input
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_byte_i,
  // result output
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       protocol_code_o,
  output logic [15:0]      payload_offset_o,
  output logic             fcs_known_o,
  output logic             fcs_present_o
);

  localparam int unsigned CntW = clhc_pkg::CntW;
  localparam int unsigned IdxW = clhc_pkg::IdxW;
  localparam int unsigned PosW = clhc_pkg::PosW;

  // ---------------------------------------------------------------- config
  logic [15:0] link_type_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_type_q <= 16'd1;
    end else if (cfg_we_i) begin
      link_type_q <= cfg_wdata_i;
    end
  end

  // ----------------------------------------------------------- input stage
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;
  logic       out_free;
  logic       s1_adv;
  logic       in_take;

  assign out_free   = !out_valid_o || !out_stall_i;
  // non-last bytes make no result and always move on
  assign s1_adv     = s1_valid_q && (!s1_last_q || out_free);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_byte_q <= data_byte_i;
      s1_last_q <= last_byte_i;
    end
  end

  // ---------------------------------------------------------- record state
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [31:0]     hdr_q, hdr_d;      // bytes 0-3 LE; it_len is [31:16]
  logic [1:0]      pres_q, pres_d;    // low two bits of first present word
  logic [15:0]     cwp_q, cwp_d;      // current present word position
  logic [1:0]      chain_q, chain_d;
  logic [15:0]     flags_pos_q, flags_pos_d;
  logic            fcs_bit_q, fcs_bit_d;

  logic [IdxW-1:0] idx;
  logic            take;
  logic [15:0]     hlen;
  logic [PosW-1:0] idx_w, cwp_w, hlen_w, next_w, pos_w, pos_rnd;

  assign idx    = cnt_q[IdxW-1:0];
  assign take   = (cnt_q < CntW'(clhc_pkg::MaxRecordBytes));
  assign hlen   = hdr_d[31:16];
  assign idx_w  = PosW'(idx);
  assign cwp_w  = PosW'(cwp_q);
  assign hlen_w = PosW'(hlen);
  assign next_w = cwp_w + PosW'(4);
  // TSFT present: skip to 8-byte alignment plus the 8-byte field
  assign pos_rnd = (next_w + PosW'(7)) & ~PosW'(7);
  assign pos_w   = pres_d[0] ? (pos_rnd + PosW'(8)) : next_w;

  // header bytes 0-4 are folded in first; the chain walk reads them this cycle
  always_comb begin
    hdr_d  = hdr_q;
    pres_d = pres_q;
    if (s1_adv && take) begin
      if (idx_w < PosW'(4)) begin
        hdr_d[idx[1:0]*8 +: 8] = s1_byte_q;
      end
      if (idx_w == PosW'(4)) begin
        pres_d = s1_byte_q[1:0];
      end
    end
  end

  always_comb begin
    cnt_d       = cnt_q;
    cwp_d       = cwp_q;
    chain_d     = chain_q;
    flags_pos_d = flags_pos_q;
    fcs_bit_d   = fcs_bit_q;
    if (s1_adv && take) begin
      cnt_d = cnt_q + CntW'(1);
      if (chain_q == clhc_pkg::ChainWalk && idx_w == cwp_w + PosW'(3)) begin
        if (s1_byte_q[7]) begin
          // extended present bitmap: next word must fit in the header
          if (next_w + PosW'(4) > hlen_w) begin
            chain_d = clhc_pkg::ChainNoFcs;
          end else begin
            cwp_d = next_w[15:0];
          end
        end else if (!pres_d[1]) begin
          chain_d = clhc_pkg::ChainNoFcs;
        end else if (pos_w >= hlen_w) begin
          chain_d = clhc_pkg::ChainNoFcs;
        end else begin
          flags_pos_d = pos_w[15:0];
          chain_d     = clhc_pkg::ChainFlagsWait;
        end
      end else if (chain_q == clhc_pkg::ChainFlagsWait && idx == flags_pos_q) begin
        fcs_bit_d = s1_byte_q[4];
        chain_d   = clhc_pkg::ChainFlagsSeen;
      end
    end
  end

  logic rec_end;
  assign rec_end = s1_adv && s1_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      hdr_q       <= '0;
      pres_q      <= '0;
      cwp_q       <= 16'd4;
      chain_q     <= clhc_pkg::ChainWalk;
      flags_pos_q <= '0;
      fcs_bit_q   <= 1'b0;
    end else if (rec_end) begin
      cnt_q       <= '0;
      hdr_q       <= '0;
      pres_q      <= '0;
      cwp_q       <= 16'd4;
      chain_q     <= clhc_pkg::ChainWalk;
      flags_pos_q <= '0;
      fcs_bit_q   <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      hdr_q       <= hdr_d;
      pres_q      <= pres_d;
      cwp_q       <= cwp_d;
      chain_q     <= chain_d;
      flags_pos_q <= flags_pos_d;
      fcs_bit_q   <= fcs_bit_d;
    end
  end

  // -------------------------------------------------------- result decode
  clhc_pkg::proto_e proto;
  logic [15:0]      offset;
  logic             known;
  logic             present;

  always_comb begin
    proto   = clhc_pkg::ProtoNone;
    offset  = '0;
    known   = 1'b0;
    present = 1'b0;
    unique case (link_type_q)
      clhc_pkg::LinkNull: begin
        offset = clhc_pkg::NullHdrLen;
        if (hdr_d == clhc_pkg::FamInet) begin
          proto = clhc_pkg::ProtoIpv4;
        end else if (hdr_d == clhc_pkg::FamInet6A || hdr_d == clhc_pkg::FamInet6B ||
                     hdr_d == clhc_pkg::FamInet6C) begin
          proto = clhc_pkg::ProtoIpv6;
        end
      end
      clhc_pkg::LinkEthernet: proto = clhc_pkg::ProtoEth;
      clhc_pkg::LinkRaw: begin
        proto = (hdr_d[7:4] == clhc_pkg::IpVersion6) ? clhc_pkg::ProtoIpv6
                                                     : clhc_pkg::ProtoIpv4;
      end
      clhc_pkg::LinkIpv4: proto = clhc_pkg::ProtoIpv4;
      clhc_pkg::LinkIpv6: proto = clhc_pkg::ProtoIpv6;
      clhc_pkg::LinkWlan: proto = clhc_pkg::ProtoWlan;
      clhc_pkg::LinkLrWpan: begin
        proto   = clhc_pkg::ProtoLrWpan;
        known   = 1'b1;
        present = 1'b1;
      end
      clhc_pkg::LinkLrWpanNoFcs: begin
        proto = clhc_pkg::ProtoLrWpan;
        known = 1'b1;
      end
      clhc_pkg::LinkRadiotap: begin
        proto   = clhc_pkg::ProtoWlan;
        offset  = hlen;
        known   = 1'b1;
        present = (chain_d == clhc_pkg::ChainFlagsSeen) && fcs_bit_d;
      end
      clhc_pkg::LinkPpp: proto = clhc_pkg::ProtoPpp;
      default: ;
    endcase
  end

  // ------------------------------------------------------ result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_free) begin
      out_valid_o <= rec_end;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rec_end) begin
      protocol_code_o  <= proto;
      payload_offset_o <= offset;
      fcs_known_o      <= known;
      fcs_present_o    <= present;
    end
  end

  // ------------------------------------------------------------ assertions
  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(s1_valid_q && s1_last_q))
    else $error("result without a last byte");

  a_state_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_end |=> (cnt_q == '0 && chain_q == clhc_pkg::ChainWalk))
    else $error("record state not cleared after last byte");

  a_flags_in_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (chain_q == clhc_pkg::ChainFlagsWait) |-> (flags_pos_q < hdr_q[31:16]))
    else $error("flags position beyond it_len");

  a_fcs_needs_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!fcs_present_o || fcs_known_o))
    else $error("fcs present without fcs known");

endmodule

`default_nettype wire
